// ----- hw/rtl/wblru_pkg.sv -----
`default_nettype none
package wblru_pkg;

	localparam int LINES = 64;
	localparam int IDX_W = $clog2(LINES);
	localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_PWRITE = 3'd1;
	localparam logic [2:0] OP_FWRITE = 3'd2;
	localparam logic [2:0] OP_FLUSH  = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [1:0] KIND_DONE  = 2'd0;
	localparam logic [1:0] KIND_WB    = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;

	typedef struct packed {
		logic load;
		logic match;
		logic decide;
		logic emit_wb;
		logic emit_fetch;
		logic emit_done;
		logic emit_flush;
		logic set_dirty;
		logic clear;
	} wblru_cmd_t;

	typedef struct packed {
		logic hit;
		logic victim_dirty;
		logic any_dirty;
		logic flush_last;
		logic out_free;
	} wblru_sts_t;

	function automatic logic [IDX_W-1:0] first_set(input logic [LINES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == SAT_MAX) ? c : c + 32'd1;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/wblru_if.sv -----
`default_nettype none
interface wblru_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] sector;
	modport source (output valid, opcode, sector, input ready);
	modport sink (input valid, opcode, sector, output ready);
endinterface

interface wblru_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  entry_index;
	logic [31:0] disk_sector;
	logic        was_hit;
	logic        last;
	logic [31:0] hit_total;
	logic [31:0] request_total;
	logic [31:0] writeback_total;
	modport source (output valid, kind, entry_index, disk_sector, was_hit, last,
		hit_total, request_total, writeback_total, input ready);
	modport sink (input valid, kind, entry_index, disk_sector, was_hit, last,
		hit_total, request_total, writeback_total, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/write_back_lru_cache_directory.sv -----
`default_nettype none
// Directory and controller of a 64-line fully associative write-back sector cache with
// true LRU replacement. Each request transfer on req carries an opcode and a sector; the
// block answers with a sequence of result transfers on res (write-back, fetch, done) and
// flags the final one with last. Requests are handled one at a time: a hit passes through
// accept, parallel tag compare, priority select and done, a miss adds a step for each
// write-back or fetch command, and a flush emits one write-back per dirty line, or none
// when nothing is dirty. The sequencer stalls only while the output register is full and
// res.ready is low. Unused opcodes are accepted and produce nothing.
module write_back_lru_cache_directory
	import wblru_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	wblru_req_if.sink   req,
	wblru_res_if.source res
);

	// Command and status bundles between the sequencer and the directory datapath.
	wblru_cmd_t cmd;
	wblru_sts_t sts;

	wblru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_opcode (req.opcode),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds tags, valid and dirty bits, LRU ranks, the counters and the
	// output register, so a finished result can wait while the sequencer moves on.
	wblru_dpath u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_sector           (req.sector),
		.cmd                 (cmd),
		.sts                 (sts),
		.out_valid           (res.valid),
		.out_ready           (res.ready),
		.out_kind            (res.kind),
		.out_entry_index     (res.entry_index),
		.out_disk_sector     (res.disk_sector),
		.out_was_hit         (res.was_hit),
		.out_last            (res.last),
		.out_hit_total       (res.hit_total),
		.out_request_total   (res.request_total),
		.out_writeback_total (res.writeback_total)
	);

	// A fetch is always followed by its done result.
	a_fetch_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_FETCH |-> !res.last)
		else $error("fetch transfer flagged as last");

	// Every done result closes its request.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_DONE |-> res.last)
		else $error("done transfer not flagged as last");

	// Only a done result can report a hit.
	a_hit_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.was_hit |-> res.kind == KIND_DONE)
		else $error("hit reported on a command transfer");

endmodule
`default_nettype wire

// ----- hw/rtl/wblru_ctrl.sv -----
`default_nettype none
module wblru_ctrl
	import wblru_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] in_opcode,
	input  wire wblru_sts_t sts,
	output wblru_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MATCH  = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_WB     = 3'd3;
	localparam logic [2:0] ST_FETCH  = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;
	localparam logic [2:0] ST_FLUSH  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_READ;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) op_q <= in_opcode;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_opcode) inside
						OP_READ, OP_PWRITE, OP_FWRITE: state_d = ST_MATCH;
						OP_FLUSH, OP_CLEAR:            state_d = ST_FLUSH;
						default:                       state_d = ST_IDLE;
					endcase
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.hit) state_d = ST_DONE;
				else if (sts.victim_dirty) state_d = ST_WB;
				else if (op_q != OP_FWRITE) state_d = ST_FETCH;
				else state_d = ST_DONE;
			end
			ST_WB: begin
				if (sts.out_free) begin
					cmd.emit_wb = 1'b1;
					state_d = (op_q != OP_FWRITE) ? ST_FETCH : ST_DONE;
				end
			end
			ST_FETCH: begin
				if (sts.out_free) begin
					cmd.emit_fetch = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit_done = 1'b1;
					cmd.set_dirty = (op_q != OP_READ);
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!sts.any_dirty) begin
					cmd.clear = (op_q == OP_CLEAR);
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit_flush = 1'b1;
					if (sts.flush_last) begin
						cmd.clear = (op_q == OP_CLEAR);
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/wblru_dpath.sv -----
`default_nettype none
module wblru_dpath
	import wblru_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] in_sector,
	input  wire wblru_cmd_t  cmd,
	output wblru_sts_t       sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       out_kind,
	output logic [5:0]       out_entry_index,
	output logic [31:0]      out_disk_sector,
	output logic             out_was_hit,
	output logic             out_last,
	output logic [31:0]      out_hit_total,
	output logic [31:0]      out_request_total,
	output logic [31:0]      out_writeback_total
);

	logic [31:0]      tag_q [LINES];
	logic [LINES-1:0] valid_q, dirty_q;
	logic [IDX_W-1:0] rank_q [LINES];
	logic [31:0]      sector_q;
	logic [LINES-1:0] match_s1;
	logic             hit_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      hit_cnt_q, req_cnt_q, wb_cnt_q;
	logic             out_valid_q;

	logic [LINES-1:0] match_c, victim_oh;
	logic             hit_c;
	logic [IDX_W-1:0] victim_idx, sel_idx, flush_idx;
	logic [LINES-1:0] flush_rest;

	always_comb begin
		for (int i = 0; i < LINES; i++) begin
			match_c[i]   = valid_q[i] && (tag_q[i] == sector_q);
			victim_oh[i] = (rank_q[i] == '0);
		end
		hit_c      = |match_s1;
		victim_idx = first_set(victim_oh);
		sel_idx    = hit_c ? first_set(match_s1) : victim_idx;
		flush_idx  = first_set(dirty_q);
		flush_rest = dirty_q & ~(LINES'(1) << flush_idx);
	end

	assign sts.hit          = hit_c;
	assign sts.victim_dirty = dirty_q[sel_idx];
	assign sts.any_dirty    = |dirty_q;
	assign sts.flush_last   = (flush_rest == '0);
	assign sts.out_free     = !out_valid_q || out_ready;

	// Tag store: no reset, only read where the line is valid.
	always_ff @(posedge clk) begin
		if (cmd.emit_done) tag_q[idx_q] <= sector_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) sector_q <= in_sector;
		if (cmd.match) match_s1 <= match_c;
		if (cmd.decide) begin
			hit_q <= hit_c;
			idx_q <= sel_idx;
		end
		if (cmd.emit_wb || cmd.emit_fetch || cmd.emit_done || cmd.emit_flush) begin
			out_kind            <= (cmd.emit_fetch) ? KIND_FETCH :
			                       (cmd.emit_done) ? KIND_DONE : KIND_WB;
			out_entry_index     <= 6'(cmd.emit_flush ? flush_idx : idx_q);
			out_disk_sector     <= cmd.emit_wb ? tag_q[idx_q] :
			                       cmd.emit_flush ? tag_q[flush_idx] : sector_q;
			out_was_hit         <= cmd.emit_done && hit_q;
			out_last            <= cmd.emit_done || (cmd.emit_flush && (flush_rest == '0));
			out_hit_total       <= hit_cnt_q;
			out_request_total   <= req_cnt_q;
			out_writeback_total <= (cmd.emit_wb || cmd.emit_flush) ? sat_inc(wb_cnt_q)
			                                                       : wb_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			hit_cnt_q   <= '0;
			req_cnt_q   <= '0;
			wb_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LINES; i++) rank_q[i] <= IDX_W'(i);
		end else begin
			if (cmd.emit_wb || cmd.emit_fetch || cmd.emit_done || cmd.emit_flush)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (cmd.decide) begin
				req_cnt_q <= sat_inc(req_cnt_q);
				if (hit_c) hit_cnt_q <= sat_inc(hit_cnt_q);
			end
			if (cmd.emit_wb) begin
				dirty_q[idx_q] <= 1'b0;
				wb_cnt_q       <= sat_inc(wb_cnt_q);
			end
			if (cmd.emit_flush) begin
				dirty_q[flush_idx] <= 1'b0;
				wb_cnt_q           <= sat_inc(wb_cnt_q);
			end
			if (cmd.emit_done) begin
				valid_q[idx_q] <= 1'b1;
				if (cmd.set_dirty) dirty_q[idx_q] <= 1'b1;
				for (int i = 0; i < LINES; i++) begin
					if (rank_q[i] > rank_q[idx_q]) rank_q[i] <= rank_q[i] - 1'b1;
				end
				rank_q[idx_q] <= IDX_W'(LINES - 1);
			end
			if (cmd.clear) begin
				hit_cnt_q <= '0;
				req_cnt_q <= '0;
				wb_cnt_q  <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
